// ===== rtl/sgb_pkg.sv =====
// Package for the separable blur: shared widths, types, register map and
// the round-and-saturate helper. No dependencies.
package sgb_pkg;

    localparam int PIX_W     = 16;
    localparam int MAX_W     = 64;
    localparam int MAX_H     = 64;
    localparam int MAX_R     = 7;
    localparam int NTAPS     = 2 * MAX_R + 1;
    localparam int NPAIR     = MAX_R + 1;
    localparam int NLINES    = 2 * MAX_R;
    localparam int POS_W     = 6;
    localparam int DIM_W     = 7;
    localparam int RAD_W     = 3;
    localparam int CNT_W     = 13;
    localparam int TIDX_W    = 4;
    localparam int PRE_W     = PIX_W + 1;
    localparam int PROD_W    = PRE_W + 16;
    localparam int HALF_W    = PROD_W + 2;
    localparam int ACC_W     = PROD_W + 3;
    localparam int FRAC_BITS = 15;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RADIUS = 3'd2;
    localparam logic [2:0] REG_NEAR   = 3'd3;
    localparam logic [2:0] REG_FAR    = 3'd4;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [NTAPS-1:0][PIX_W-1:0] taps_t;
    typedef logic [NPAIR-1:0][15:0] wts_t;

    typedef struct packed {
        logic             valid;
        logic             vv;
        logic [POS_W-1:0] ocol;
        logic [POS_W-1:0] orow;
        logic             last;
    } meta_t;

    function automatic pix_t round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0]           sum;
        logic [ACC_W-FRAC_BITS:0] q;
        begin
            sum = {1'b0, acc} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
            q   = sum[ACC_W:FRAC_BITS];
            if (|q[ACC_W-FRAC_BITS:PIX_W]) begin
                round_sat = {PIX_W{1'b1}};
            end else begin
                round_sat = q[PIX_W-1:0];
            end
        end
    endfunction

endpackage

// ===== rtl/sgb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sgb_line_cell.sv =====
// One line-delay cell: holds one row of horizontal results and passes the
// delayed word to the next cell. Depends on sgb_pkg and sgb_ram.
module sgb_line_cell (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [sgb_pkg::POS_W-1:0]  rd_addr,
    input  logic                       wr_en,
    input  logic [sgb_pkg::POS_W-1:0]  wr_addr,
    input  sgb_pkg::pix_t              wr_data,
    output sgb_pkg::pix_t              rd_data
);
    import sgb_pkg::*;

    pix_t ram_q;
    pix_t byp_reg;
    logic hit_reg;

    sgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_W)) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // forward a same-address write when one row is a single pixel
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hit_reg <= wr_en && (wr_addr == rd_addr);
            byp_reg <= wr_data;
        end
    end

    assign rd_data = hit_reg ? byp_reg : ram_q;

endmodule

// ===== rtl/sgb_fir.sv =====
// Symmetric clamped FIR over a 15-word tap vector: select, pre-add pairs,
// multiply, add, round. Four register stages. Depends on sgb_pkg.
module sgb_fir (
    input  logic                      aclk,
    input  logic                      en,
    input  sgb_pkg::taps_t            taps,
    input  logic [sgb_pkg::RAD_W-1:0] radius,
    input  logic [sgb_pkg::POS_W-1:0] pos,
    input  logic [sgb_pkg::POS_W-1:0] lim,
    input  sgb_pkg::wts_t             wts,
    output sgb_pkg::pix_t             res
);
    import sgb_pkg::*;

    logic [PRE_W-1:0]  pre_next [NPAIR];
    logic [PRE_W-1:0]  pre_reg  [NPAIR];
    logic [PROD_W-1:0] prod_reg [NPAIR];
    logic [HALF_W-1:0] suma_reg;
    logic [HALF_W-1:0] sumb_reg;
    pix_t              res_reg;

    always_comb begin
        logic [POS_W-1:0]  span;
        logic [POS_W-1:0]  kk;
        logic [POS_W-1:0]  mhi;
        logic [POS_W-1:0]  mlo;
        logic [TIDX_W-1:0] ihi;
        logic [TIDX_W-1:0] ilo;
        span = lim - pos;
        pre_next[0] = {1'b0, taps[TIDX_W'(radius)]};
        for (int k = 1; k < NPAIR; k++) begin
            kk  = POS_W'(k);
            mhi = (span < kk) ? span : kk;
            mlo = (pos < kk) ? pos : kk;
            ihi = TIDX_W'(radius) - TIDX_W'(mhi);
            ilo = TIDX_W'(radius) + TIDX_W'(mlo);
            if (kk <= POS_W'(radius)) begin
                pre_next[k] = {1'b0, taps[ihi]} + {1'b0, taps[ilo]};
            end else begin
                pre_next[k] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NPAIR; k++) begin
                pre_reg[k]  <= pre_next[k];
                prod_reg[k] <= PROD_W'(pre_reg[k]) * PROD_W'(wts[k]);
            end
            suma_reg <= HALF_W'(prod_reg[0]) + HALF_W'(prod_reg[1])
                      + HALF_W'(prod_reg[2]) + HALF_W'(prod_reg[3]);
            sumb_reg <= HALF_W'(prod_reg[4]) + HALF_W'(prod_reg[5])
                      + HALF_W'(prod_reg[6]) + HALF_W'(prod_reg[7]);
            res_reg  <= round_sat(ACC_W'(suma_reg) + ACC_W'(sumb_reg));
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/separable_gaussian_blur.sv =====
// Top level of the separable blur: config port, counters, horizontal FIR,
// chain of line cells, vertical FIR and output skid stage.
// Depends on sgb_pkg, sgb_fir, sgb_line_cell (and through it sgb_ram).
//
// Usage:
//   Pixels enter on the s_ stream in raster order, one word per pixel, and
//   the client appends R*W+R padding words after each frame. Blurred pixels
//   leave on the m_ stream with their column and row; tlast marks the last
//   pixel of the frame. Warm-up words produce no output word.
//   One word per cycle is sustained in both directions while m_tready is
//   high; the result caused by a word passes the tap window, four horizontal
//   FIR stages, four vertical FIR stages and one output register to m_tvalid.
//   The line cells hold one row each in a 64-entry RAM read ahead of the write.
//   The user must write registers over APB only while the stream is idle;
//   the block does not enforce it. W, H and R feed the counters directly.
//   Reset clears the counters, the tap window and the output stage and loads
//   W=64, H=64, R=0 and a unit center weight. Line memories are not cleared;
//   border clamping never reads an unwritten entry.
//   When m_tready stays low, one extra word is caught in the skid register
//   and s_tready then drops until the output drains.
module separable_gaussian_blur (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sgb_pkg::ADDR_W-1:0]    paddr,
    input  logic [sgb_pkg::DATA_W-1:0]    pwdata,
    output logic [sgb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // [15:0] pixel_in
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // [15:0] blurred_pixel,
                                                    // [21:16] out_col,
                                                    // [27:22] out_row, [31:28] 0
    output logic                          m_tlast   // frame_last
);
    import sgb_pkg::*;

    localparam int NST  = 9;
    localparam int RDST = 4;
    localparam int HST  = 5;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [RAD_W-1:0] radius_reg;
    logic [63:0]      near_reg;
    logic [63:0]      far_reg;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [POS_W-1:0] w_m1;
    logic [POS_W-1:0] h_m1;
    logic [CNT_W-1:0] pixels;
    logic [CNT_W-1:0] delay;
    wts_t             wts;

    logic             wr_cfg;
    logic [2:0]       cfg_idx;

    logic             adv;
    logic             accept;
    logic [CNT_W-1:0] m_reg;
    logic [POS_W-1:0] hcol_reg;
    logic [POS_W-1:0] ocol_reg;
    logic [POS_W-1:0] orow_reg;
    logic             hv;
    logic             vv;
    logic             wrap;
    logic             last;

    taps_t            window_reg;
    logic [POS_W-1:0] hcol0_reg;
    meta_t            meta_reg [NST];

    logic [POS_W-1:0] rd_ptr_reg;
    logic [POS_W-1:0] wa_reg;
    logic             rd_en;
    logic             wr_en;

    pix_t             hpass;
    taps_t            vtaps;
    pix_t             vres;

    logic             push;
    logic [31:0]      push_data;
    logic             out_valid_reg;
    logic [31:0]      out_data_reg;
    logic             out_last_reg;
    logic             skid_valid_reg;
    logic [31:0]      skid_data_reg;
    logic             skid_last_reg;

    // configuration
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign wr_cfg  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(MAX_W);
            height_reg <= DIM_W'(MAX_H);
            radius_reg <= '0;
            near_reg   <= 64'd32768;
            far_reg    <= '0;
        end else if (wr_cfg) begin
            unique case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_RADIUS: radius_reg <= pwdata[RAD_W-1:0];
                REG_NEAR:   near_reg   <= pwdata;
                REG_FAR:    far_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            REG_RADIUS: prdata = DATA_W'(radius_reg);
            REG_NEAR:   prdata = near_reg;
            REG_FAR:    prdata = far_reg;
            default:    prdata = '0;
        endcase
    end

    assign w_eff  = (width_reg == '0) ? DIM_W'(1)
                  : (width_reg > DIM_W'(MAX_W)) ? DIM_W'(MAX_W) : width_reg;
    assign h_eff  = (height_reg == '0) ? DIM_W'(1)
                  : (height_reg > DIM_W'(MAX_H)) ? DIM_W'(MAX_H) : height_reg;
    assign w_m1   = POS_W'(w_eff - DIM_W'(1));
    assign h_m1   = POS_W'(h_eff - DIM_W'(1));
    assign pixels = CNT_W'(w_eff) * CNT_W'(h_eff);
    assign delay  = CNT_W'(radius_reg) * CNT_W'(w_eff) + CNT_W'(radius_reg);
    assign wts    = {far_reg, near_reg};

    // frame counters
    assign adv    = !skid_valid_reg;
    assign accept = s_tvalid && adv;
    assign hv     = (m_reg >= CNT_W'(radius_reg))
                 && ((m_reg - CNT_W'(radius_reg)) < pixels);
    assign vv     = (m_reg >= delay) && ((m_reg - delay) < pixels);
    assign wrap   = ({1'b0, m_reg} + 14'd1) >= ({1'b0, pixels} + {1'b0, delay});
    assign last   = vv && (ocol_reg == w_m1) && (orow_reg == h_m1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_reg    <= '0;
            hcol_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end else if (accept) begin
            if (wrap) begin
                m_reg    <= '0;
                hcol_reg <= '0;
                ocol_reg <= '0;
                orow_reg <= '0;
            end else begin
                m_reg <= m_reg + CNT_W'(1);
                if (hv) begin
                    hcol_reg <= (hcol_reg >= w_m1) ? '0 : hcol_reg + POS_W'(1);
                end
                if (vv) begin
                    if (ocol_reg >= w_m1) begin
                        ocol_reg <= '0;
                        orow_reg <= orow_reg + POS_W'(1);
                    end else begin
                        ocol_reg <= ocol_reg + POS_W'(1);
                    end
                end
            end
        end
    end

    // tap window and metadata pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (accept) begin
            window_reg <= {window_reg[NTAPS-2:0], s_tdata};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hcol0_reg <= hcol_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NST; i++) begin
                meta_reg[i] <= '0;
            end
        end else if (adv) begin
            meta_reg[0] <= '{valid: s_tvalid, vv: vv, ocol: ocol_reg,
                             orow: orow_reg, last: last};
            for (int i = 1; i < NST; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    sgb_fir u_hfir (
        .aclk   (aclk),
        .en     (adv),
        .taps   (window_reg),
        .radius (radius_reg),
        .pos    (hcol0_reg),
        .lim    (w_m1),
        .wts    (wts),
        .res    (hpass)
    );

    // line cells: read one stage ahead, write with the item
    assign rd_en = adv && meta_reg[RDST-1].valid;
    assign wr_en = adv && meta_reg[HST-1].valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
        end else if (rd_en) begin
            rd_ptr_reg <= (rd_ptr_reg >= w_m1) ? '0 : rd_ptr_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wa_reg <= rd_ptr_reg;
        end
    end

    assign vtaps[0] = hpass;

    for (genvar d = 1; d <= NLINES; d++) begin : g_line
        sgb_line_cell u_cell (
            .aclk    (aclk),
            .rd_en   (rd_en),
            .rd_addr (rd_ptr_reg),
            .wr_en   (wr_en),
            .wr_addr (wa_reg),
            .wr_data (vtaps[d-1]),
            .rd_data (vtaps[d])
        );
    end

    sgb_fir u_vfir (
        .aclk   (aclk),
        .en     (adv),
        .taps   (vtaps),
        .radius (radius_reg),
        .pos    (meta_reg[HST-1].orow),
        .lim    (h_m1),
        .wts    (wts),
        .res    (vres)
    );

    // output register with skid
    assign push      = adv && meta_reg[NST-1].valid && meta_reg[NST-1].vv;
    assign push_data = {4'b0000, meta_reg[NST-1].orow, meta_reg[NST-1].ocol, vres};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg   <= skid_data_reg;
                out_last_reg   <= skid_last_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= push_data;
                out_last_reg  <= meta_reg[NST-1].last;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= push_data;
                skid_last_reg  <= meta_reg[NST-1].last;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
